// ===== design/rdio_pkg.sv =====
// Shared types and constants for the in-order duplicate remover.
package rdio_pkg;

  localparam int DEPTH      = 64;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_of_set;
  } in_t;

  typedef struct packed {
    logic signed [31:0] unique_value;
    logic               last_of_run;
    logic               overflow;
  } out_t;

endpackage

// ===== design/rdio_obuf.sv =====
// Small output queue that decouples the store read-out from the output stall.
module rdio_obuf (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  rdio_pkg::out_t                    push_data_i,
  output logic [rdio_pkg::OBUF_CNT_W-1:0]   count_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rdio_pkg::out_t                    out_data_o
);
  import rdio_pkg::*;

  out_t                  entry_q [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OBUF_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OBUF_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && (cnt_q == OBUF_CNT_W'(OBUF_DEPTH))))
    else $error("output queue written while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OBUF_CNT_W'(OBUF_DEPTH))
    else $error("output queue count out of range");

endmodule

// ===== design/remove_duplicates_in_order.sv =====
// Top level: in-order duplicate remover built around one distinct-value memory.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  input   | in        | in_valid_i / in_stall_o    | in_data_i  (value, last_of_set)
//  output  | out       | out_valid_o / out_stall_i  | out_data_o (unique_value,
//          |           |                            |  last_of_run, overflow)
//
// An input transaction searches the stored distinct values in order from entry 0 and ends at
// the first repeat or after the last stored value, storing the value if new and not full:
// the search reads the memory one entry per cycle (one read port).
// A marked transaction then reads out every stored entry, one per cycle while the output
// queue has room; the next input is taken once the final entry is in the queue and the state is idle.
// Reset clears the count and the overflow flag; the memory needs no clearing.
// Output stall only holds the read-out; finished results wait in a 4-entry queue.
module remove_duplicates_in_order (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rdio_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rdio_pkg::out_t out_data_o
);
  import rdio_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [ADDR_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      emit_q, emit_d;
  logic                  ovf_q, ovf_d;
  logic signed [31:0]    value_q, value_d;
  logic                  last_q, last_d;
  logic                  pend_q, pend_d;
  logic                  pend_last_q, pend_last_d;

  logic [31:0]           mem [DEPTH];
  logic [31:0]           rd_data_q;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;

  logic [OBUF_CNT_W-1:0] obuf_cnt;
  logic                  room;
  logic                  hit;
  logic                  search_end;
  out_t                  push_data;

  assign in_stall_o = (state_q != ST_IDLE);

  assign hit        = (count_q != '0) && (rd_data_q == value_q);
  assign search_end = (count_q == '0) || ({1'b0, idx_q} + 1'b1 == count_q);
  assign room       = ({1'b0, obuf_cnt} + {{OBUF_CNT_W{1'b0}}, pend_q})
                      < (OBUF_CNT_W+1)'(OBUF_DEPTH);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    emit_d      = emit_q;
    ovf_d       = ovf_q;
    value_d     = value_q;
    last_d      = last_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          value_d = in_data_i.value;
          last_d  = in_data_i.last_of_set;
          idx_d   = '0;
          rd_en   = 1'b1;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit || search_end) begin
          if (!hit) begin
            if (count_q < CNT_W'(DEPTH)) begin
              wr_en   = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          emit_d  = '0;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end else begin
          // advance to the next stored entry
          idx_d   = idx_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if ((emit_q < count_q) && room) begin
          rd_en       = 1'b1;
          rd_addr     = emit_q[ADDR_W-1:0];
          emit_d      = emit_q + 1'b1;
          pend_d      = 1'b1;
          pend_last_d = (emit_q + 1'b1 == count_q);
        end
        // final entry lands in the queue: clear for the next set
        if (pend_q && pend_last_q) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      idx_q       <= '0;
      emit_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      idx_q       <= idx_d;
      emit_q      <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[ADDR_W-1:0]] <= value_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign push_data.unique_value = rd_data_q;
  assign push_data.last_of_run  = pend_last_q;
  assign push_data.overflow     = ovf_q;

  rdio_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pend_q),
    .push_data_i (push_data),
    .count_o     (obuf_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("distinct count beyond capacity");

  a_hit_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) && hit |=> $stable(count_q))
    else $error("repeat value changed the distinct count");

  a_pend_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == ST_EMIT))
    else $error("read-out outside of emit phase");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && pend_last_q |=> (count_q == '0) && !ovf_q && (state_q == ST_IDLE))
    else $error("set not cleared after final result");

endmodule

// ===== tb/tb_remove_duplicates_in_order.sv =====
// Self-checking testbench for the in-order duplicate remover.
module tb_remove_duplicates_in_order;
  import rdio_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 200;
  localparam int TARGET_ITEMS = 450;
  localparam int REPORT_MAX  = 40;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  remove_duplicates_in_order DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  in_t         values_to_send[$];
  out_t        uniques_due[$];
  logic [31:0] kept_vals[DEPTH];
  int          kept_count;
  bit          dropped_any;

  int mismatches;
  int values_taken;
  int sets_taken;
  int uniques_checked;
  int overflow_uniques;
  int idle_cycles;

  // Dedup model: keep first occurrences, flush the kept list on the marked value.
  task automatic dedup_predict(in_t item);
    bit found;
    out_t res;
    found = 1'b0;
    for (int i = 0; i < kept_count; i++)
      if (kept_vals[i] == item.value) found = 1'b1;
    if (!found) begin
      if (kept_count < DEPTH) begin
        kept_vals[kept_count] = item.value;
        kept_count++;
      end else begin
        dropped_any = 1'b1;
      end
    end
    if (item.last_of_set) begin
      for (int k = 0; k < kept_count; k++) begin
        res.unique_value = kept_vals[k];
        res.last_of_run  = (k == kept_count - 1);
        res.overflow     = dropped_any;
        uniques_due.push_back(res);
      end
      kept_count  = 0;
      dropped_any = 1'b0;
      sets_taken++;
    end
  endtask

  function automatic int pick_idle(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_value(logic [31:0] v, bit last);
    in_t item;
    item.value       = v;
    item.last_of_set = last;
    values_to_send.push_back(item);
  endtask

  // Many repeats drawn from a small pool, extremes mixed in.
  task automatic add_short_set();
    logic [31:0] pool[8];
    int pool_n;
    int len;
    pool_n = $urandom_range(1, 8);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
    for (int i = 0; i < pool_n; i++) begin
      case ($urandom_range(0, 9))
        0:       pool[i] = 32'h8000_0000;
        1:       pool[i] = 32'h7fff_ffff;
        2:       pool[i] = 32'h0000_0000;
        3:       pool[i] = 32'hffff_ffff;
        default: pool[i] = $urandom;
      endcase
    end
    for (int i = 0; i < len; i++)
      add_value(pool[$urandom_range(0, pool_n - 1)], i == len - 1);
  endtask

  // Fill the store to capacity; optionally push extra distinct values past it.
  task automatic add_full_set(bit extra_new, bit marked_new);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < DEPTH; i++) begin
      add_value(base + i, 1'b0);
      if ($urandom_range(0, 3) == 0) add_value(base + $urandom_range(0, i), 1'b0);
    end
    if (extra_new) begin
      for (int j = 0; j < 3; j++) add_value(base + DEPTH + j, 1'b0);
      add_value(base + $urandom_range(0, DEPTH - 1), 1'b0);
    end
    add_value(marked_new ? base + 200 : base + $urandom_range(0, DEPTH - 1), 1'b1);
  endtask

  // Input driver
  int in_gap_left;
  bit in_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_data_i   <= '0;
      in_gap_left = 0;
      in_calm     = 1'b0;
    end else begin
      bit busy;
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        dedup_predict(in_data_i);
        values_taken++;
        busy = 1'b0;
        if ($urandom_range(0, 40) == 0) in_calm = !in_calm;
      end
      if (!busy) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid_i <= 1'b0;
        end else if (values_to_send.size() > 0) begin
          in_valid_i  <= 1'b1;
          in_data_i   <= values_to_send.pop_front();
          in_gap_left = pick_idle(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall generator
  int out_stall_left;
  bit out_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      out_stall_left = 0;
      out_calm       = 1'b0;
    end else begin
      int n;
      out_t want;
      if (out_valid_o && !out_stall_i) begin
        if (uniques_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result value=%h last=%b ovf=%b", $time,
                     out_data_o.unique_value, out_data_o.last_of_run,
                     out_data_o.overflow);
        end else begin
          want = uniques_due.pop_front();
          uniques_checked++;
          if (want.overflow) overflow_uniques++;
          if (out_data_o.unique_value !== want.unique_value ||
              out_data_o.last_of_run !== want.last_of_run ||
              out_data_o.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: mismatch expected value=%h last=%b ovf=%b, got value=%h last=%b ovf=%b",
                       $time, want.unique_value, want.last_of_run, want.overflow,
                       out_data_o.unique_value, out_data_o.last_of_run,
                       out_data_o.overflow);
          end
        end
        if ($urandom_range(0, 40) == 0) out_calm = !out_calm;
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
      end else begin
        n = pick_idle(out_calm);
        out_stall_i    <= (n > 0);
        out_stall_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, uniques_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    bit full_exact_done;
    bit full_drop_done;
    bit full_drop_rep_done;
    full_exact_done    = 1'b0;
    full_drop_done     = 1'b0;
    full_drop_rep_done = 1'b0;
    kept_count  = 0;
    dropped_any = 1'b0;
    idle_cycles = 0;

    // Single-element set, minimum value.
    add_value(32'h8000_0000, 1'b1);
    // Extremes with repeats; marked value is a repeat.
    add_value(32'h7fff_ffff, 1'b0);
    add_value(32'h7fff_ffff, 1'b0);
    add_value(32'h0000_0000, 1'b0);
    add_value(32'hffff_ffff, 1'b0);
    add_value(32'h0000_0000, 1'b0);
    add_value(32'hffff_ffff, 1'b1);
    // Values that differ only in the sign bit must stay distinct.
    add_value(32'h0000_0001, 1'b0);
    add_value(32'h8000_0001, 1'b0);
    add_value(32'h0000_0001, 1'b0);
    add_value(32'h8000_0001, 1'b1);
    // Alternating bit patterns.
    add_value(32'h5555_5555, 1'b0);
    add_value(32'haaaa_aaaa, 1'b0);
    add_value(32'h5555_5555, 1'b0);
    add_value(32'haaaa_aaaa, 1'b1);
    // All repeats collapse to one result.
    add_value(32'h0000_0007, 1'b0);
    add_value(32'h0000_0007, 1'b0);
    add_value(32'h0000_0007, 1'b1);

    while (values_to_send.size() < TARGET_ITEMS) begin
      if (!full_exact_done && values_to_send.size() >= 80) begin
        add_full_set(1'b0, 1'b0);
        full_exact_done = 1'b1;
      end else if (!full_drop_done && values_to_send.size() >= 220) begin
        add_full_set(1'b1, 1'b1);
        full_drop_done = 1'b1;
      end else if (!full_drop_rep_done && values_to_send.size() >= 360) begin
        add_full_set(1'b1, 1'b0);
        full_drop_rep_done = 1'b1;
      end else begin
        add_short_set();
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    do @(posedge clk_i);
    while (values_to_send.size() > 0 || in_valid_i || uniques_due.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run covered %0d input values in %0d sets, %0d results checked.",
             values_taken, sets_taken, uniques_checked);
    $display("Full-store sets included; %0d results carried the overflow flag.",
             overflow_uniques);
    if (mismatches == 0 && uniques_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
